>>> design/collatz_record_search_macros.svh
// Assertion macros shared by the collatz record search checker.
`ifndef COLLATZ_RECORD_SEARCH_MACROS_SVH
`define COLLATZ_RECORD_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crs check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crs check failed: next-cycle rule");

`endif

>>> design/crs_pkg.sv
// Shared types and constants for the collatz record search block.
`default_nettype none

package crs_pkg;

    localparam int PATH_BITS = 16;
    // path counter holds limit + 1 so a two-count step never wraps
    localparam int PATH_W = PATH_BITS + 1;
    localparam logic [PATH_W-1:0] PATH_LIMIT = PATH_W'((64'd1 << PATH_BITS) - 64'd1);

    localparam int VAL_W = 64;
    localparam int LEN_W = 16;
    localparam int OUT_W = 88;  // 84 field bits padded to whole bytes

    localparam logic [VAL_W-1:0] SEARCH_END_RESET = 64'h0000_0001_0000_0000;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_PATH_LIMIT = 2'd2,
        ST_DONE       = 2'd3
    } status_t;

    typedef struct packed {
        logic load;    // take a start value
        logic step;    // advance the sequence one step
        logic finish;  // settle records, fill the output register
    } crs_cmd_t;

    typedef struct packed {
        logic done;    // run ended (reached one or stopped)
    } crs_stat_t;

endpackage

`default_nettype wire

>>> design/crs_datapath.sv
// Datapath: sequence registers, step unit, records, output payload.
`default_nettype none

module crs_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire crs_pkg::crs_cmd_t          cmd,
    output crs_pkg::crs_stat_t              stat,
    input  wire logic                       cfg_we,
    input  wire logic [crs_pkg::VAL_W-1:0]  cfg_data,
    input  wire logic [crs_pkg::VAL_W-1:0]  start_value,
    output logic      [crs_pkg::OUT_W-1:0]  out_data
);

    logic [crs_pkg::VAL_W-1:0]  search_end_reg;
    logic [crs_pkg::VAL_W-1:0]  record_peak_reg;
    logic [crs_pkg::PATH_BITS-1:0] record_path_reg;

    logic [crs_pkg::VAL_W-1:0]  cur_reg, cur_next;
    logic [crs_pkg::VAL_W-1:0]  peak_reg, peak_next;
    logic [crs_pkg::PATH_W-1:0] path_reg, path_next;
    crs_pkg::status_t           status_reg, status_next;

    logic [crs_pkg::LEN_W-1:0]  o_len_reg;
    logic [crs_pkg::VAL_W-1:0]  o_peak_reg;
    logic                       o_newpk_reg;
    logic                       o_newpa_reg;
    crs_pkg::status_t           o_status_reg;

    logic                       odd;
    logic                       cur_one;
    logic [crs_pkg::VAL_W:0]    odd_sum;
    logic [crs_pkg::PATH_W-1:0] path_sum;
    logic                       beat_peak;
    logic                       beat_path;

    assign odd     = cur_reg[0];
    assign cur_one = (cur_reg == crs_pkg::VAL_W'(1));
    // (3n+1)/2 as n + (n>>1) + 1; carry out means overflow
    assign odd_sum = {1'b0, cur_reg} + {2'b00, cur_reg[crs_pkg::VAL_W-1:1]}
                     + (crs_pkg::VAL_W+1)'(1);
    assign path_sum = path_reg + (odd ? crs_pkg::PATH_W'(2) : crs_pkg::PATH_W'(1));

    assign stat.done = (status_reg != crs_pkg::ST_OK) || cur_one;

    assign beat_peak = (status_reg == crs_pkg::ST_OK) && (record_peak_reg < peak_reg);
    assign beat_path = (status_reg == crs_pkg::ST_OK)
                       && ({1'b0, record_path_reg} < path_reg);

    always_comb
    begin
        cur_next    = cur_reg;
        peak_next   = peak_reg;
        path_next   = path_reg;
        status_next = status_reg;
        if (cmd.load)
        begin
            cur_next    = start_value;
            peak_next   = '0;
            path_next   = '0;
            status_next = (start_value > search_end_reg) ? crs_pkg::ST_DONE
                                                         : crs_pkg::ST_OK;
        end
        else if (cmd.step && !stat.done)
        begin
            if (odd && odd_sum[crs_pkg::VAL_W])
            begin
                status_next = crs_pkg::ST_OVERFLOW;
            end
            else
            begin
                if (odd)
                begin
                    cur_next = odd_sum[crs_pkg::VAL_W-1:0];
                    if (odd_sum[crs_pkg::VAL_W-1:0] > peak_reg)
                        peak_next = odd_sum[crs_pkg::VAL_W-1:0];
                end
                else
                begin
                    cur_next = cur_reg >> 1;
                end
                if (path_sum >= crs_pkg::PATH_LIMIT)
                begin
                    path_next   = crs_pkg::PATH_LIMIT;
                    status_next = crs_pkg::ST_PATH_LIMIT;
                end
                else
                begin
                    path_next = path_sum;
                end
            end
        end
    end

    // sequence and output registers: payload, no reset needed
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        peak_reg <= peak_next;
        path_reg <= path_next;
        if (cmd.finish)
        begin
            o_len_reg    <= crs_pkg::LEN_W'(path_reg);
            o_peak_reg   <= peak_reg;
            o_newpk_reg  <= beat_peak;
            o_newpa_reg  <= beat_path;
            o_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= crs_pkg::ST_OK;
            search_end_reg  <= crs_pkg::SEARCH_END_RESET;
            record_peak_reg <= '0;
            record_path_reg <= '0;
        end
        else
        begin
            status_reg <= status_next;
            if (cfg_we)
                search_end_reg <= cfg_data;
            if (cmd.finish && beat_peak)
                record_peak_reg <= peak_reg;
            if (cmd.finish && beat_path)
                record_path_reg <= crs_pkg::PATH_BITS'(path_reg);
        end
    end

    assign out_data = {4'b0000, o_status_reg, o_newpa_reg, o_newpk_reg,
                       o_peak_reg, o_len_reg};

endmodule

`default_nettype wire

>>> design/crs_ctrl.sv
// Controller: accepts a start, steps the datapath, hands off the result beat.
`default_nettype none

module crs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire crs_pkg::crs_stat_t stat,
    output crs_pkg::crs_cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.step   = (state_reg == S_RUN) && !stat.done;
    assign cmd.finish = (state_reg == S_RUN) && stat.done && slot_free;
    assign m_tvalid   = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (cmd.finish)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/collatz_record_search.sv
// Top level of the collatz record search block.
//
// Input stream (s_*): one beat per start value, s_tdata[63:0] = start_value.
// Output stream (m_*): one beat per start value, fields listed at m_tdata.
// Config channel (cfg_*): cfg_data writes search_end; cfg_ready is always high.
//   Write it only while no start value is in flight.
// Operation: an input beat loads the start value and checks the search end,
// then the datapath takes one sequence step per cycle (an odd combined step
// counts two in path_length), then the result loads the output register.
// A start beyond search_end is not stepped. The single step unit runs one
// start value at a time: a new start is taken only after the last result
// has loaded the output register. s_tready is high only between runs.
// Reset: search_end returns to 2^32, record peak and path clear, no beat
// is pending on the output.
// Stall: the output register holds a finished beat while m_tready is low;
// a new start is still taken and run, and its result waits in the datapath
// until the output register is free.
`default_nettype none

module collatz_record_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] start_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [15:0] path_length, [79:16] half_peak,
                                        // [80] new_peak_record,
                                        // [81] new_path_record, [83:82] status,
                                        // [87:84] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data   // search_end
);

    crs_pkg::crs_cmd_t  cmd;
    crs_pkg::crs_stat_t stat;

    // config register always writable
    assign cfg_ready = 1'b1;

    crs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .start_value (s_tdata),
        .out_data    (m_tdata)
    );

endmodule

`default_nettype wire

>>> design/crs_checker.sv
// Port-level checker for collatz_record_search, bound to the top level.
`default_nettype none
`include "collatz_record_search_macros.svh"

module crs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata
);

    crs_pkg::status_t out_status;
    logic             out_not_ok;
    logic             out_done;
    logic             out_limit;

    assign out_status = crs_pkg::status_t'(m_tdata[83:82]);
    assign out_not_ok = m_tvalid && (out_status != crs_pkg::ST_OK);
    assign out_done   = m_tvalid && (out_status == crs_pkg::ST_DONE);
    assign out_limit  = m_tvalid && (out_status == crs_pkg::ST_PATH_LIMIT);

    // stalled result beat stays put
    `CRS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one start at a time: no input taken right after an input beat
    `CRS_ASSERT_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // any stop other than ok leaves the record flags clear
    `CRS_ASSERT_NOW(a_flags_ok, clk, rst_n, out_not_ok, m_tdata[81:80] == 2'b00)

    // beyond the search end nothing was run
    `CRS_ASSERT_NOW(a_done_empty, clk, rst_n, out_done, m_tdata[79:0] == 80'd0)

    // path limit stop reports the limit
    `CRS_ASSERT_NOW(a_limit_len, clk, rst_n, out_limit, m_tdata[15:0] == 16'(crs_pkg::PATH_LIMIT))

endmodule

bind collatz_record_search crs_checker u_crs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
